@@ src/fixed_weight_vector_sampler_unit_macros.svh @@
// Assertion macros shared by the fixed-weight vector sampler RTL
`ifndef FIXED_WEIGHT_VECTOR_SAMPLER_UNIT_MACROS_SVH
`define FIXED_WEIGHT_VECTOR_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FWVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FWVS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fwvs_pkg.sv @@
// Shared types and constants of the fixed-weight vector sampler
package fwvs_pkg;

    localparam int KEY_W  = 16;   // widest position / word key
    localparam int WORD_W = 64;
    localparam int CIDX_W = 8;    // cell index, up to 256 cells
    localparam int CFG_W  = 7;

    localparam logic APB_REG_WEIGHT = 1'b0;
    localparam logic OP_LOAD        = 1'b0;
    localparam logic OP_READ        = 1'b1;

    // beat travelling down the cell row
    typedef struct packed {
        logic              vld;
        logic              dedup;  // 1: duplicate probe, 0: word readout
        logic [KEY_W-1:0]  key;    // probe position or word index
        logic              hit;
        logic [WORD_W-1:0] acc;
    } t_lane;

    // control broadcast to every cell
    typedef struct packed {
        logic              wr_en;
        logic [CIDX_W-1:0] wr_idx;
        logic [KEY_W-1:0]  wr_pos;
        logic [CIDX_W-1:0] weight;
        logic [CIDX_W-1:0] ptr;
    } t_cell_ctl;

endpackage

@@ src/fwvs_cell.sv @@
// One cell of the position row: holds one position, updates the passing beat
module fwvs_cell #(
    parameter int POS_W = 15,
    parameter int IDX   = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fwvs_pkg::t_cell_ctl i_ctl,
    input  fwvs_pkg::t_lane     i_lane,
    output fwvs_pkg::t_lane     o_lane
);
    import fwvs_pkg::*;

    localparam logic [CIDX_W-1:0] MY_IDX = CIDX_W'(IDX);

    logic [POS_W-1:0] r_pos;
    t_lane            r_lane;
    t_lane            n_lane;
    logic [KEY_W-1:0] w_pos_ext;
    logic             w_act;

    assign w_pos_ext = KEY_W'(r_pos);
    assign w_act     = MY_IDX < i_ctl.weight;

    always_comb begin
        n_lane = i_lane;
        if (i_lane.dedup) begin
            if (MY_IDX == i_ctl.ptr) begin
                n_lane.key = w_pos_ext;
            end else if (MY_IDX > i_ctl.ptr && w_act && w_pos_ext == i_lane.key) begin
                n_lane.hit = 1'b1;
            end
        end else if (w_act && (w_pos_ext >> 6) == i_lane.key) begin
            n_lane.acc = i_lane.acc | (WORD_W'(1) << r_pos[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_idx == MY_IDX) begin
            r_pos <= i_ctl.wr_pos[POS_W-1:0];
        end
        r_lane <= n_lane;
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end
    end

    assign o_lane = r_lane;
endmodule

@@ src/fwvs_sampler.sv @@
// Position sampler: i + (word mod (N-i)) by Barrett estimate, five steps
module fwvs_sampler #(
    parameter int VECTOR_BITS = 17669,
    parameter int MAX_WEIGHT  = 75,
    parameter int IW          = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_word,
    input  logic [IW-1:0]            i_idx,
    output logic                     o_done,
    output logic [fwvs_pkg::KEY_W-1:0] o_pos
);
    import fwvs_pkg::*;

    logic [32:0]       w_recip [MAX_WEIGHT];
    logic [4:0]        r_stg;
    logic [31:0]       r_a;
    logic [32:0]       r_rc;
    logic [16:0]       r_ns;
    logic [IW-1:0]     r_i;
    logic [47:0]       r_plo;
    logic [48:0]       r_phi;
    logic [31:0]       r_q;
    logic [31:0]       r_r;
    logic [31:0]       w_t;
    logic [31:0]       w_rf;
    logic [KEY_W-1:0]  r_pos;
    logic              r_done;
    logic [16:0]       w_ns;
    logic [15:0]       w_n;

    // reciprocal table floor(2^32 / (VECTOR_BITS - k))
    for (genvar k = 0; k < MAX_WEIGHT; k++) begin : g_rc
        localparam longint NS = longint'(VECTOR_BITS) - longint'(k);
        localparam longint DEN = (NS >= 1) ? NS : 1;
        localparam longint RC = 64'h1_0000_0000 / DEN;
        assign w_recip[k] = 33'(RC);
    end

    assign w_ns = 17'(VECTOR_BITS) - 17'(i_idx);
    assign w_n  = r_ns[15:0];
    assign w_t  = r_r - 32'(w_n);
    assign w_rf = w_t[31] ? r_r : w_t;

    always_ff @(posedge i_clk) begin
        r_stg  <= {r_stg[3:0], i_start};
        r_done <= r_stg[4];
        if (i_start) begin
            r_a  <= i_word;
            r_rc <= w_recip[i_idx];
            r_ns <= w_ns;
            r_i  <= i_idx;
        end
        if (r_stg[0]) r_plo <= 48'(r_a) * 48'(r_rc[15:0]);
        if (r_stg[1]) r_phi <= 49'(r_a) * 49'(r_rc[32:16]);
        if (r_stg[2]) r_q   <= 32'((50'(r_phi) + 50'(r_plo >> 16)) >> 16);
        if (r_stg[3]) r_r   <= r_a - r_q * 32'(w_n);
        if (r_stg[4]) begin
            if (r_ns[16] || r_ns == 17'd0) begin
                r_pos <= KEY_W'(r_i);
            end else begin
                r_pos <= KEY_W'(32'(r_i) + w_rf);
            end
        end
        if (!i_rst_n) begin
            r_stg  <= '0;
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_pos  = r_pos;
endmodule

@@ src/fixed_weight_vector_sampler_unit.sv @@
// Fixed-weight vector sampler top level: handshakes, control FSM, cell row
//
// Usage:
//  - Input beat (s_axis): tuser[0] = opcode (0 load, 1 read), tuser[1] = first.
//    tdata[31:0] = rand_word, tdata[40:32] = word_index, rest zero.
//  - A load turns a 32-bit random word into the next position; first restarts
//    the vector. Loads give no output beat. A load runs the five-step Barrett
//    sampler, then writes the position into the row.
//  - A read gives one output beat: tdata = 64-bit vector word, tuser = the
//    incomplete flag (fewer than weight loads so far; data is then zero).
//  - A read walks one beat through the row of MAX_WEIGHT cells, one cell per
//    cycle. The first read after a full set of loads first runs the duplicate
//    pass, one row walk per entry but the last (none for a weight below 2).
//  - One item is in work at a time; s_axis tready is high only when idle.
//  - The result sits in an output register; a stalled receiver holds it
//    while the next item is already accepted and worked on.
//  - Reset (synchronous, active low): weight = 75, no words loaded, output
//    empty. Positions are not cleared; they are only read once loaded.
//  - APB: weight at address 0; user writes only while idle (unchecked); clears count.
module fixed_weight_vector_sampler_unit #(
    parameter int VECTOR_BITS  = 17669,
    parameter int MAX_WEIGHT   = 75,
    parameter int VECTOR_WORDS = 277
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [31:0] rand_word, [40:32] word_index
    input  logic [1:0]  s_axis_tuser,  // [0] opcode, [1] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [63:0] word_value
    output logic        m_axis_tuser   // [0] incomplete
);
    import fwvs_pkg::*;

    `include "fixed_weight_vector_sampler_unit_macros.svh"

    localparam int POS_W = $clog2(VECTOR_BITS);
    localparam int IW    = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_DDUP = 5'b00100,
        S_READ = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_weight;
    logic [CFG_W-1:0]  r_count;
    logic              r_dd_done;
    logic [CIDX_W-1:0] r_ptr;
    logic [KEY_W-1:0]  r_key;
    logic              r_oor;
    t_lane             r_inj;
    logic [WORD_W-1:0] r_res;
    logic              r_res_inc;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_data;
    logic              r_out_inc;

    logic [CFG_W-1:0]  w_eff;
    logic              w_in_acc;
    logic              w_cfg_wr;
    logic              w_op;
    logic              w_first;
    logic [31:0]       w_word;
    logic [8:0]        w_widx;
    logic [CFG_W-1:0]  w_cnt0;
    logic              w_smp_start;
    logic              w_smp_done;
    logic [KEY_W-1:0]  w_smp_pos;
    logic              w_exit;
    logic              w_push;
    t_cell_ctl         w_ctl;
    t_lane             w_lane [MAX_WEIGHT+1];

    assign w_op     = s_axis_tuser[0];
    assign w_first  = s_axis_tuser[1];
    assign w_word   = s_axis_tdata[31:0];
    assign w_widx   = s_axis_tdata[40:32];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_eff    = (9'(r_weight) > 9'(MAX_WEIGHT)) ? CFG_W'(MAX_WEIGHT) : r_weight;
    assign w_cnt0   = w_first ? '0 : r_count;
    assign w_exit   = w_lane[MAX_WEIGHT].vld;
    assign w_push   = (r_state == S_PUSH) && (!r_out_vld || m_axis_tready);

    assign w_smp_start = w_in_acc && w_op == OP_LOAD && w_cnt0 < w_eff;

    // APB
    assign pready = 1'b1;
    assign prdata = 32'(r_weight);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_inc;

    // row control: writes come from the sampler or the duplicate pass
    always_comb begin
        w_ctl        = '0;
        w_ctl.weight = CIDX_W'(w_eff);
        w_ctl.ptr    = r_ptr;
        if (r_state == S_LOAD && w_smp_done) begin
            w_ctl.wr_en  = 1'b1;
            w_ctl.wr_idx = CIDX_W'(r_count);
            w_ctl.wr_pos = w_smp_pos;
        end else if (r_state == S_DDUP && w_exit && w_lane[MAX_WEIGHT].hit) begin
            w_ctl.wr_en  = 1'b1;
            w_ctl.wr_idx = r_ptr;
            w_ctl.wr_pos = KEY_W'(r_ptr);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_op == OP_LOAD) begin
                        if (w_smp_start) n_state = S_LOAD;
                    end else if (r_count < w_eff) begin
                        n_state = S_PUSH;
                    end else if (!r_dd_done && w_eff >= CFG_W'(2)) begin
                        n_state = S_DDUP;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_LOAD: if (w_smp_done) n_state = S_IDLE;
            S_DDUP: if (w_exit && r_ptr == '0) n_state = S_READ;
            S_READ: if (w_exit) n_state = S_PUSH;
            S_PUSH: if (w_push) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_state   <= n_state;
        r_inj.vld <= 1'b0;

        if (w_cfg_wr && paddr[2] == APB_REG_WEIGHT) begin
            r_weight  <= pwdata[CFG_W-1:0];
            r_count   <= '0;
            r_dd_done <= 1'b0;
        end

        if (r_state == S_IDLE && w_in_acc) begin
            if (w_op == OP_LOAD) begin
                if (w_first) begin
                    r_count   <= '0;
                    r_dd_done <= 1'b0;
                end
            end else begin
                r_key <= KEY_W'(w_widx);
                r_oor <= 11'(w_widx) >= 11'(VECTOR_WORDS);
                if (r_count < w_eff) begin
                    r_res     <= '0;
                    r_res_inc <= 1'b1;
                end else begin
                    r_inj.vld <= 1'b1;
                    r_inj.hit <= 1'b0;
                    r_inj.acc <= '0;
                    if (!r_dd_done && w_eff >= CFG_W'(2)) begin
                        r_ptr       <= CIDX_W'(w_eff - CFG_W'(2));
                        r_inj.dedup <= 1'b1;
                        r_inj.key   <= '0;
                    end else begin
                        r_dd_done   <= 1'b1;
                        r_inj.dedup <= 1'b0;
                        r_inj.key   <= KEY_W'(w_widx);
                    end
                end
            end
        end

        if (r_state == S_LOAD && w_smp_done) begin
            r_count <= r_count + CFG_W'(1);
        end

        // duplicate pass: one row walk per entry but the last, highest such entry first
        if (r_state == S_DDUP && w_exit) begin
            r_inj.vld <= 1'b1;
            r_inj.hit <= 1'b0;
            r_inj.acc <= '0;
            if (r_ptr == '0) begin
                r_dd_done   <= 1'b1;
                r_inj.dedup <= 1'b0;
                r_inj.key   <= r_key;
            end else begin
                r_ptr       <= r_ptr - CIDX_W'(1);
                r_inj.dedup <= 1'b1;
                r_inj.key   <= '0;
            end
        end

        if (r_state == S_READ && w_exit) begin
            r_res     <= r_oor ? '0 : w_lane[MAX_WEIGHT].acc;
            r_res_inc <= 1'b0;
        end

        // output register
        if (w_push) begin
            r_out_vld  <= 1'b1;
            r_out_data <= r_res;
            r_out_inc  <= r_res_inc;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end

        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_weight  <= CFG_W'(75);
            r_count   <= '0;
            r_dd_done <= 1'b0;
            r_ptr     <= '0;
            r_inj.vld <= 1'b0;
            r_out_vld <= 1'b0;
        end
    end

    fwvs_sampler #(
        .VECTOR_BITS (VECTOR_BITS),
        .MAX_WEIGHT  (MAX_WEIGHT),
        .IW          (IW)
    ) u_sampler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_smp_start),
        .i_word  (w_word),
        .i_idx   (IW'(w_cnt0)),
        .o_done  (w_smp_done),
        .o_pos   (w_smp_pos)
    );

    assign w_lane[0] = r_inj;

    for (genvar k = 0; k < MAX_WEIGHT; k++) begin : g_cell
        fwvs_cell #(
            .POS_W (POS_W),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_lane  (w_lane[k]),
            .o_lane  (w_lane[k+1])
        );
    end

    `FWVS_ASSERT_IMP(a_cnt_bound, 1'b1, r_count <= w_eff, "load count above weight")
    `FWVS_ASSERT_IMP(a_dd_full, r_dd_done, r_count == w_eff, "dedup done on partial vector")
    `FWVS_ASSERT_IMP(a_exit_state, w_exit, r_state == S_DDUP || r_state == S_READ,
        "row beat outside walk")
    `FWVS_ASSERT_IMP(a_smp_state, w_smp_done, r_state == S_LOAD, "sampler done while not loading")
    `FWVS_ASSERT_NXT(a_push_out, w_push, r_out_vld, "pushed result not presented")

endmodule

@@ dv/fixed_weight_vector_sampler_unit_test.sv @@
// Self-checking testbench for the fixed-weight vector sampler unit
`timescale 1ns / 100ps

module fixed_weight_vector_sampler_unit_test;
    import fwvs_pkg::*;

    localparam int NBITS     = 17669;
    localparam int NWORDS    = 277;
    localparam int WMAX      = 75;
    localparam int CYC_LIMIT = 2000000;
    localparam int ITEM_GOAL = 550;

    // one input beat before packing; aim_* are resolved when the beat is driven
    typedef struct {
        logic        op;
        logic        first;
        logic [31:0] rword;
        logic [8:0]  widx;
        bit          aim_word;  // read a word that holds a stored position
        bit          aim_dup;   // load a word that lands on a stored position
    } t_sample_item;

    typedef struct {
        logic [63:0] word;
        logic        incomplete;
    } t_vec_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // [31:0] rand_word, [40:32] word_index
    logic [1:0]  s_axis_tuser = '0;  // [0] opcode, [1] first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // [63:0] word_value
    logic        m_axis_tuser;       // [0] incomplete

    fixed_weight_vector_sampler_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the sampler state
    logic [14:0] pos_tbl [WMAX];
    int unsigned n_loaded, weight_reg;
    bit          dedup_ran;
    t_vec_word   exp_words[$];
    t_sample_item pending[$];
    t_sample_item cur;
    int unsigned cyc, err_cnt, n_loads, n_reads, n_incomplete, n_nonzero, n_vectors;
    bit          quiet, hold_done;
    int unsigned hold_left;

    function automatic int unsigned eff_weight();
        return (weight_reg > WMAX) ? WMAX : weight_reg;
    endfunction

    // Barrett estimate of a mod (N-i), one conditional subtract, offset by i
    function automatic logic [14:0] barrett_position(logic [31:0] a, int unsigned i);
        logic [63:0] recip, q;
        logic [31:0] n, r, t;
        if (NBITS - int'(i) < 1) return i[14:0];
        n     = NBITS - i;
        recip = 64'h1_0000_0000 / n;
        q     = ({32'b0, a} * recip) >> 32;
        r     = a - q[31:0] * n;
        t     = r - n;
        if (!t[31]) r = t;
        return 15'(i + r);
    endfunction

    // later entry wins; an earlier duplicate falls back to its own index
    task automatic drop_duplicates(int unsigned w);
        bit hit;
        for (int i = int'(w) - 2; i >= 0; i--) begin
            hit = 0;
            for (int j = i + 1; j < int'(w); j++)
                if (pos_tbl[j] == pos_tbl[i]) hit = 1;
            if (hit) pos_tbl[i] = 15'(i);
        end
    endtask

    task automatic predict_beat(t_sample_item it);
        int unsigned w;
        t_vec_word   r;
        w = eff_weight();
        if (it.op == OP_LOAD) begin
            n_loads++;
            if (it.first) begin
                n_loaded  = 0;
                dedup_ran = 0;
            end
            if (n_loaded < w) begin
                pos_tbl[n_loaded] = barrett_position(it.rword, n_loaded);
                n_loaded++;
            end
        end else begin
            n_reads++;
            r.word = '0;
            r.incomplete = 1'b0;
            if (n_loaded < w) begin
                r.incomplete = 1'b1;
                n_incomplete++;
            end else begin
                if (!dedup_ran) begin
                    drop_duplicates(w);
                    dedup_ran = 1;
                end
                if (it.widx < NWORDS)
                    for (int j = 0; j < int'(w); j++)
                        if (pos_tbl[j][14:6] == it.widx) r.word[pos_tbl[j][5:0]] = 1'b1;
                if (r.word != 0) n_nonzero++;
            end
            exp_words.push_back(r);
        end
    endtask

    // quiet window: no idling on either side
    always @(posedge i_clk) begin
        cyc   <= cyc + 1;
        quiet <= (cyc % 60000) < 10000;
        if (cyc >= CYC_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // driver: one beat per handshake, next beat resolved against the shadow state
    always @(posedge i_clk) begin : drv
        bit take;
        take = s_axis_tvalid && s_axis_tready;
        if (take) predict_beat(cur);
        if ((!s_axis_tvalid || take) && pending.size() > 0 && i_rst_n
                && (quiet || $urandom_range(99) >= 14)) begin
            cur = pending.pop_front();
            if (cur.aim_word && n_loaded > 0)
                cur.widx = pos_tbl[$urandom_range(n_loaded - 1)][14:6];
            if (cur.aim_dup && n_loaded > 0 && n_loaded < eff_weight()) begin
                // pick a stored position reachable from this slot
                for (int k = 0; k < int'(n_loaded); k++)
                    if (pos_tbl[k] >= n_loaded) cur.rword = pos_tbl[k] - n_loaded;
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {7'b0, cur.widx, cur.rword};
            s_axis_tuser  <= {cur.first, cur.op};
        end else if (take) begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: random backpressure, one long hold-off once two reads are queued
    always @(posedge i_clk) begin : mon
        t_vec_word e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (exp_words.size() == 0) begin
                $error("unexpected beat: word_value %h incomplete %b",
                       m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                e = exp_words.pop_front();
                if (m_axis_tdata !== e.word) begin
                    $error("word_value: expected %h, got %h", e.word, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tuser !== e.incomplete) begin
                    $error("incomplete: expected %b, got %b", e.incomplete, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
        if (!hold_done && exp_words.size() >= 2 && cyc > 2000) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && (quiet || $urandom_range(99) >= 14);
        end
    end

    task automatic set_weight(int unsigned w);
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {APB_REG_WEIGHT, 2'b00};
        pwdata <= 32'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        weight_reg = w;
        n_loaded   = 0;
        dedup_ran  = 0;
    endtask

    function automatic t_sample_item mk(logic op, logic first, logic [31:0] rw,
                                         logic [8:0] wi, bit aw = 0, bit ad = 0);
        t_sample_item it;
        it.op = op; it.first = first; it.rword = rw; it.widx = wi;
        it.aim_word = aw; it.aim_dup = ad;
        return it;
    endfunction

    // wait for the block to drain; loads leave no beat, so allow their latency
    task automatic drain();
        while (pending.size() != 0 || s_axis_tvalid || exp_words.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // one vector: mostly clean load sets with reads, some broken or noisy
    task automatic queue_vector(int unsigned w);
        int unsigned nl;
        int          kind;
        kind = $urandom_range(9);
        nl   = (kind == 0) ? $urandom_range(w) : w + ((kind == 1) ? $urandom_range(3) : 0);
        if (kind == 2)
            pending.push_back(mk(OP_READ, 1'($urandom_range(1)), $urandom, 9'($urandom)));
        for (int k = 0; k < int'(nl); k++)
            pending.push_back(mk(OP_LOAD, k == 0, $urandom, 9'($urandom),
                                 0, $urandom_range(5) == 0));
        repeat ($urandom_range(1, 4))
            pending.push_back(mk(OP_READ, 1'($urandom_range(1)), $urandom, 9'($urandom),
                                 $urandom_range(3) != 0));
        n_vectors++;
    endtask

    int unsigned queued;
    int unsigned w_pick;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        weight_reg = 75;

        // directed, weight 2: incomplete read, duplicate pass, extra load, index edges
        set_weight(2);
        pending.push_back(mk(OP_READ, 1, 32'h0, 9'd0));
        pending.push_back(mk(OP_LOAD, 1, 32'h0, 9'h1ff));
        pending.push_back(mk(OP_LOAD, 0, 32'hffff_ffff, 9'h0));
        pending.push_back(mk(OP_LOAD, 0, 32'h1234_5678, 9'h0));   // ignored, set full
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'd0));
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'd276));
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'd277));
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'h1ff));
        // both entries land on position 5: earlier one falls back to index 0
        pending.push_back(mk(OP_LOAD, 1, 32'd5, 9'd0));
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'd0));           // still incomplete
        pending.push_back(mk(OP_LOAD, 0, 32'd4, 9'd0));
        pending.push_back(mk(OP_READ, 1, 32'h0, 9'd0));
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'd0));
        drain();
        set_weight(1);
        pending.push_back(mk(OP_LOAD, 1, 32'hdead_beef, 9'd0));
        pending.push_back(mk(OP_READ, 0, 32'h0, 9'd0, 1));
        drain();
        set_weight(75);
        queue_vector(75);
        drain();

        // random phases, mostly small weights, a few full-size sets
        queued = 0;
        while (n_loads + n_reads + pending.size() < ITEM_GOAL) begin
            case ($urandom_range(5))
                0:       w_pick = 75;
                1:       w_pick = 1;
                default: w_pick = $urandom_range(2, 12);
            endcase
            set_weight(w_pick);
            repeat ($urandom_range(1, 4)) queue_vector(w_pick);
            drain();
        end

        $display("covered %0d loads, %0d reads (%0d incomplete, %0d nonzero words)",
                 n_loads, n_reads, n_incomplete, n_nonzero);
        $display("over %0d vectors in %0d cycles", n_vectors, cyc);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
